// ===== rtl/anbs_pkg.sv =====
// Shared types and constants for the Annex B NAL boundary scanner.
package anbs_pkg;

   localparam int BYTE_W     = 8;
   localparam int OFFSET_W   = 22;
   localparam int SIZE_W     = 23;
   localparam int LIMIT_W    = 5;
   localparam int RECENT_W   = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int EV_KIND_W  = 2;

   localparam int MAX_FRAME_BYTES_DEF = 4194304;
   localparam int EVQ_DEPTH_DEF       = 4;

   // distance from the 01 byte back to the first 00 of the start code
   localparam int SC_BACK = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_P_RESET = 5'd2;
   localparam logic [LIMIT_W-1:0] LIMIT_I_RESET = 5'd4;
   localparam logic [LIMIT_W-1:0] COUNT_SAT     = 5'd31;
   localparam logic [LIMIT_W-1:0] LIMIT_MIN     = 5'd2;
   localparam logic [BYTE_W-1:0]  SC_LAST_BYTE  = 8'h01;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NAL_LIMIT_P = 1'b0,
      CSR_NAL_LIMIT_I = 1'b1
   } csr_idx_type;

   // events handed from the scanner front to the result back end
   typedef enum logic [EV_KIND_W-1:0] {
      EV_OPEN      = 2'd0,  // first start code: opens a NAL, no result
      EV_CLOSE     = 2'd1,  // later start code: closes open NAL, opens next
      EV_END_OPEN  = 2'd2,  // frame end with a NAL open
      EV_END_EMPTY = 2'd3   // frame end with nothing open
   } ev_kind_type;

endpackage

// ===== rtl/anbs_ifs.sv =====
// Channel interfaces of the Annex B NAL boundary scanner.
interface anbs_req_if;
   logic                          valid;
   logic                          ready;
   logic [anbs_pkg::BYTE_W-1:0]   data_byte;
   logic                          frame_first;
   logic                          frame_last;
   logic                          frame_is_p;

   modport source (output valid, data_byte, frame_first, frame_last, frame_is_p,
                   input ready);
   modport sink   (input valid, data_byte, frame_first, frame_last, frame_is_p,
                   output ready);
endinterface

interface anbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [anbs_pkg::OFFSET_W-1:0] nal_offset;
   logic [anbs_pkg::SIZE_W-1:0]   nal_length;
   logic                          nal_found;
   logic                          frame_done;

   modport source (output valid, nal_offset, nal_length, nal_found, frame_done,
                   input ready);
   modport sink   (input valid, nal_offset, nal_length, nal_found, frame_done,
                   output ready);
endinterface

interface anbs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [anbs_pkg::CSR_IDX_W-1:0] index;
   logic [anbs_pkg::LIMIT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/annexb_nal_boundary_scanner.sv =====
// H.264 Annex B NAL boundary scanner, top level.
// Takes one frame payload byte per item and reports each NAL unit found between
// 00 00 00 01 start codes as an offset and size; the frame's last byte closes
// the open NAL or gives an empty end marker with nal_found low. A start code
// whose 01 byte is the frame's last byte does not count, and once the frame
// has reported its limit minus one NALs (limit per P or I frame, sampled on the
// first byte, and at least 2) the scan stops. One byte per cycle is taken while
// req ready is high: a result reaches rsp through an EVQ_DEPTH-entry event
// queue and an output register. req ready drops only while that queue is full,
// which happens only when rsp is held off. Limit registers are written through
// csr, which is always ready.
module annexb_nal_boundary_scanner #(
   parameter int MAX_FRAME_BYTES = anbs_pkg::MAX_FRAME_BYTES_DEF,
   parameter int EVQ_DEPTH       = anbs_pkg::EVQ_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   anbs_req_if.sink   req_chan,
   anbs_rsp_if.source rsp_chan,
   anbs_csr_if.sink   csr_chan
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int EV_W  = anbs_pkg::EV_KIND_W + POS_W;

   logic            evq_full;
   logic            ev_push;
   logic [EV_W-1:0] ev_push_data;
   logic            ev_pop;
   logic            ev_valid;
   logic [EV_W-1:0] ev_data;

   anbs_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .POS_W           (POS_W),
      .EV_W            (EV_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .csr      (csr_chan),
      .evq_full (evq_full),
      .ev_push  (ev_push),
      .ev_data  (ev_push_data)
   );

   anbs_evq #(
      .DEPTH  (EVQ_DEPTH),
      .DATA_W (EV_W)
   ) u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_push_data),
      .full      (evq_full),
      .pop       (ev_pop),
      .pop_valid (ev_valid),
      .pop_data  (ev_data)
   );

   anbs_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .POS_W           (POS_W),
      .EV_W            (EV_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (ev_valid),
      .ev_data  (ev_data),
      .ev_pop   (ev_pop),
      .rsp      (rsp_chan)
   );

endmodule

// ===== rtl/anbs_front.sv =====
// Scanner front: takes bytes, tracks frame state and finds start codes.
module anbs_front #(
   parameter int MAX_FRAME_BYTES = anbs_pkg::MAX_FRAME_BYTES_DEF,
   parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1),
   parameter int EV_W            = anbs_pkg::EV_KIND_W + POS_W
) (
   input  logic              clock,
   input  logic              reset,
   anbs_req_if.sink          req,
   anbs_csr_if.sink          csr,
   input  logic              evq_full,
   output logic              ev_push,
   output logic [EV_W-1:0]   ev_data
);

   logic [anbs_pkg::LIMIT_W-1:0]  limit_p_ff, limit_p_in;
   logic [anbs_pkg::LIMIT_W-1:0]  limit_i_ff, limit_i_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [anbs_pkg::RECENT_W-1:0] recent_ff, recent_in;
   logic                          open_ff, open_in;
   logic [anbs_pkg::LIMIT_W-1:0]  count_ff, count_in;
   logic                          stopped_ff, stopped_in;
   logic [anbs_pkg::LIMIT_W-1:0]  limit_ff, limit_in;

   logic                          accept;
   logic [POS_W-1:0]              eff_pos, pos_upd;
   logic [anbs_pkg::RECENT_W-1:0] eff_recent;
   logic                          eff_open, eff_stopped;
   logic [anbs_pkg::LIMIT_W-1:0]  eff_count, eff_limit, count_inc;
   logic                          in_range, sc_hit;
   anbs_pkg::ev_kind_type         ev_kind;
   logic [POS_W-1:0]              ev_pos;

   assign req.ready = !evq_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   always_comb begin
      limit_p_in = limit_p_ff;
      limit_i_in = limit_i_ff;
      if (csr.valid) begin
         case (anbs_pkg::csr_idx_type'(csr.index))
            anbs_pkg::CSR_NAL_LIMIT_P: limit_p_in = csr.data;
            anbs_pkg::CSR_NAL_LIMIT_I: limit_i_in = csr.data;
            default: ;
         endcase
      end
   end

   // frame state as seen by this byte: a first byte starts from a clean frame
   always_comb begin
      eff_pos     = req.frame_first ? '0 : pos_ff;
      eff_recent  = req.frame_first ? '0 : recent_ff;
      eff_open    = req.frame_first ? 1'b0 : open_ff;
      eff_count   = req.frame_first ? '0 : count_ff;
      eff_stopped = req.frame_first ? 1'b0 : stopped_ff;
      eff_limit   = req.frame_first ? (req.frame_is_p ? limit_p_ff : limit_i_ff)
                                    : limit_ff;

      in_range  = eff_pos < POS_W'(MAX_FRAME_BYTES);
      sc_hit    = in_range && !req.frame_last && !eff_stopped
                  && (eff_pos >= POS_W'(anbs_pkg::SC_BACK))
                  && (eff_recent == '0) && (req.data_byte == anbs_pkg::SC_LAST_BYTE);
      count_inc = (eff_count != anbs_pkg::COUNT_SAT) ? eff_count + 1'b1 : eff_count;
      pos_upd   = in_range ? eff_pos + 1'b1 : eff_pos;
   end

   always_comb begin
      pos_in     = pos_ff;
      recent_in  = recent_ff;
      open_in    = open_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      limit_in   = limit_ff;
      if (accept) begin
         limit_in   = eff_limit;
         pos_in     = pos_upd;
         recent_in  = in_range ? {eff_recent[anbs_pkg::RECENT_W-anbs_pkg::BYTE_W-1:0],
                                  req.data_byte}
                               : eff_recent;
         open_in    = eff_open;
         count_in   = eff_count;
         stopped_in = eff_stopped;
         if (sc_hit) begin
            open_in = 1'b1;
            if (eff_open) begin
               count_in = count_inc;
               if (eff_limit >= anbs_pkg::LIMIT_MIN && count_inc == eff_limit - 1'b1)
                  stopped_in = 1'b1;
            end
         end
         if (req.frame_last) begin
            pos_in     = '0;
            recent_in  = '0;
            open_in    = 1'b0;
            count_in   = '0;
            stopped_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (req.frame_last) begin
         ev_kind = eff_open ? anbs_pkg::EV_END_OPEN : anbs_pkg::EV_END_EMPTY;
         ev_pos  = pos_upd;
      end else begin
         ev_kind = eff_open ? anbs_pkg::EV_CLOSE : anbs_pkg::EV_OPEN;
         ev_pos  = eff_pos - POS_W'(anbs_pkg::SC_BACK);
      end
   end

   assign ev_push = accept && (sc_hit || req.frame_last);
   assign ev_data = {ev_kind, ev_pos};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_p_ff <= anbs_pkg::LIMIT_P_RESET;
         limit_i_ff <= anbs_pkg::LIMIT_I_RESET;
         pos_ff     <= '0;
         recent_ff  <= '0;
         open_ff    <= 1'b0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         limit_ff   <= '0;
      end else begin
         limit_p_ff <= limit_p_in;
         limit_i_ff <= limit_i_in;
         pos_ff     <= pos_in;
         recent_ff  <= recent_in;
         open_ff    <= open_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         limit_ff   <= limit_in;
      end
   end

endmodule

// ===== rtl/anbs_evq.sv =====
// Small event queue between the scanner front and the result back end.
module anbs_evq #(
   parameter int DEPTH  = anbs_pkg::EVQ_DEPTH_DEF,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/anbs_back.sv =====
// Result back end: keeps the open NAL start and builds offset/size items.
module anbs_back #(
   parameter int MAX_FRAME_BYTES = anbs_pkg::MAX_FRAME_BYTES_DEF,
   parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1),
   parameter int EV_W            = anbs_pkg::EV_KIND_W + POS_W
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            ev_valid,
   input  logic [EV_W-1:0] ev_data,
   output logic            ev_pop,
   anbs_rsp_if.source      rsp
);

   localparam int OFFSET_W = anbs_pkg::OFFSET_W;
   localparam int SIZE_W   = anbs_pkg::SIZE_W;

   logic [POS_W-1:0]    open_start_ff, open_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                found_ff, found_in;
   logic                done_ff, done_in;

   anbs_pkg::ev_kind_type        ev_kind;
   logic [POS_W-1:0]             ev_pos;
   logic [POS_W-1:0]             nal_len;
   logic [POS_W+OFFSET_W-1:0]    offset_ext;
   logic [POS_W+SIZE_W-1:0]      size_ext;
   logic                         can_load;

   assign ev_kind    = anbs_pkg::ev_kind_type'(ev_data[EV_W-1 -: anbs_pkg::EV_KIND_W]);
   assign ev_pos     = ev_data[POS_W-1:0];
   assign nal_len    = ev_pos - open_start_ff;
   assign offset_ext = {{OFFSET_W{1'b0}}, open_start_ff};
   assign size_ext   = {{SIZE_W{1'b0}}, nal_len};
   assign can_load   = !rsp_valid_ff || rsp.ready;
   // an opening start code yields no item, so it never waits on the output
   assign ev_pop     = ev_valid && (ev_kind == anbs_pkg::EV_OPEN || can_load);

   always_comb begin
      open_start_in = open_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      offset_in     = offset_ff;
      size_in       = size_ff;
      found_in      = found_ff;
      done_in       = done_ff;
      if (ev_pop) begin
         case (ev_kind)
            anbs_pkg::EV_OPEN: begin
               open_start_in = ev_pos;
            end
            anbs_pkg::EV_CLOSE: begin
               open_start_in = ev_pos;
               rsp_valid_in  = 1'b1;
               offset_in     = offset_ext[OFFSET_W-1:0];
               size_in       = size_ext[SIZE_W-1:0];
               found_in      = 1'b1;
               done_in       = 1'b0;
            end
            anbs_pkg::EV_END_OPEN: begin
               rsp_valid_in  = 1'b1;
               offset_in     = offset_ext[OFFSET_W-1:0];
               size_in       = size_ext[SIZE_W-1:0];
               found_in      = 1'b1;
               done_in       = 1'b1;
            end
            anbs_pkg::EV_END_EMPTY: begin
               rsp_valid_in  = 1'b1;
               offset_in     = '0;
               size_in       = '0;
               found_in      = 1'b0;
               done_in       = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.nal_offset = offset_ff;
   assign rsp.nal_length = size_ff;
   assign rsp.nal_found  = found_ff;
   assign rsp.frame_done = done_ff;

   always_ff @(posedge clock) begin
      open_start_ff <= open_start_in;
      offset_ff     <= offset_in;
      size_ff       <= size_in;
      found_ff      <= found_in;
      done_ff       <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
